// ===== sv/double_ended_queue_assert.svh =====
// assertion macros for the double ended queue
// used by double_ended_queue.sv, no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// shared types, codes and index helpers for the double ended queue
// no dependencies
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [1:0] OP_PUSH_BACK = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_BACK = 2'd2;
	localparam logic [1:0] OP_POP_FRONT = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		data_t popped;
		data_t front;
		data_t back;
		logic empty;
		logic full;
		cnt_t count;
		logic [1:0] status;
	} deq_res_t;

	typedef struct packed {
		logic res_valid;
		logic busy;
	} deq_ctl_t;

	// circular slot of base + off, off below DEPTH
	function automatic idx_t slot_add(idx_t base, cnt_t off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return IDX_W'(s);
	endfunction

endpackage

// ===== sv/deq_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int WORDS = 16,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/deq_ctrl.sv =====
// head, count and end-value registers plus the operation sequencer
// depends on deq_pkg and drives deq_ram
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [31:0]       value,
	input  logic              out_free,
	output deq_pkg::deq_res_t res,
	output deq_pkg::deq_ctl_t ctl
);
	import deq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q, state_d;
	idx_t head_q, head_d;
	cnt_t count_q, count_d;
	data_t front_q, front_d;
	data_t back_q, back_d;
	data_t pop_q;
	logic pback_q;

	logic fire;
	logic res_valid;
	data_t val;
	data_t popped;
	logic [1:0] stat;
	logic we, re;
	idx_t waddr, raddr;
	data_t rdata;
	idx_t head_inc, head_dec;
	logic q_empty, q_full;

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.WORDS(DEPTH),
		.AW(IDX_W)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(val),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready = (state_q == S_IDLE) && out_free;
	assign fire = in_valid && in_ready;
	assign val = DATA_WIDTH'(value);
	assign head_inc = slot_add(head_q, cnt_t'(1));
	assign head_dec = slot_add(head_q, cnt_t'(DEPTH - 1));
	assign q_empty = (count_q == '0);
	assign q_full = (count_q == cnt_t'(DEPTH));

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		front_d = front_q;
		back_d = back_q;
		popped = '0;
		stat = ST_OK;
		we = 1'b0;
		re = 1'b0;
		waddr = head_q;
		raddr = head_q;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					res_valid = 1'b1;
					case (operation)
						OP_PUSH_BACK, OP_PUSH_FRONT: begin
							if (q_full) begin
								stat = ST_OVERFLOW;
							end else begin
								we = 1'b1;
								count_d = count_q + cnt_t'(1);
								if (operation == OP_PUSH_BACK) begin
									waddr = slot_add(head_q, count_q);
									back_d = val;
									if (q_empty) begin
										front_d = val;
									end
								end else begin
									waddr = head_dec;
									head_d = head_dec;
									front_d = val;
									if (q_empty) begin
										back_d = val;
									end
								end
							end
						end
						OP_POP_BACK, OP_POP_FRONT: begin
							if (q_empty) begin
								stat = ST_UNDERFLOW;
							end else begin
								count_d = count_q - cnt_t'(1);
								if (operation == OP_POP_BACK) begin
									popped = back_q;
									raddr = slot_add(head_q, count_q - cnt_t'(2));
								end else begin
									popped = front_q;
									head_d = head_inc;
									raddr = head_inc;
								end
								// new end value must come from the ram
								if (count_q != cnt_t'(1)) begin
									re = 1'b1;
									res_valid = 1'b0;
									state_d = S_READ;
								end
							end
						end
						default: begin
							stat = ST_OK;
						end
					endcase
				end
			end
			S_READ: begin
				res_valid = 1'b1;
				state_d = S_IDLE;
				popped = pop_q;
				if (pback_q) begin
					back_d = rdata;
				end else begin
					front_d = rdata;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign ctl.res_valid = res_valid;
	assign ctl.busy = (state_q == S_READ);

	assign res.popped = popped;
	assign res.front = (count_d == '0) ? '0 : front_d;
	assign res.back = (count_d == '0) ? '0 : back_d;
	assign res.empty = (count_d == '0);
	assign res.full = (count_d == cnt_t'(DEPTH));
	assign res.count = count_d;
	assign res.status = stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		front_q <= front_d;
		back_q <= back_d;
		if (fire) begin
			pop_q <= popped;
			pback_q <= (operation == OP_POP_BACK);
		end
	end

endmodule

// ===== sv/double_ended_queue.sv =====
// Bounded double ended queue of 16 entries of 32 bits. Each input beat is one
// operation (push back, push front, pop back, pop front) and yields exactly
// one output beat with the popped item, the new front and back items, the
// empty and full flags, the count and a status code. Pushes, failed pops and
// pops that empty the queue give their result directly; a pop that leaves one
// or more items passes through a ram read state, since the new front or back
// item is fetched from the entry ram, whose read data is registered.
// The front and back items are kept in registers beside the ram. The output
// register frees the input side as soon as the pending result is taken.
// Reset needs no clearing pass.
// depends on deq_pkg, deq_ctrl, deq_ram and double_ended_queue_assert.svh
`include "double_ended_queue_assert.svh"

module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] popped_value,
	output logic [31:0] front_value,
	output logic [31:0] back_value,
	output logic        is_empty,
	output logic        is_full,
	output logic [4:0]  occupancy,
	output logic [1:0]  status
);
	import deq_pkg::*;

	deq_res_t res;
	deq_ctl_t ctl;
	logic out_valid_q;
	logic out_free;
	logic [63:0] pop_w, front_w, back_w;

	assign out_free = !out_valid_q || out_ready;

	deq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.out_free(out_free),
		.res(res),
		.ctl(ctl)
	);

	assign pop_w = 64'(res.popped);
	assign front_w = 64'(res.front);
	assign back_w = 64'(res.back);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (ctl.res_valid) begin
			popped_value <= pop_w[31:0];
			front_value <= front_w[31:0];
			back_value <= back_w[31:0];
			is_empty <= res.empty;
			is_full <= res.full;
			occupancy <= 5'(res.count);
			status <= res.status;
		end
	end

	assign out_valid = out_valid_q;

	`DEQ_ASSERT_SAME(a_read_out_empty, clk, arst_n, ctl.busy, !out_valid_q, "ram read while output held")
	`DEQ_ASSERT_NEXT(a_read_done, clk, arst_n, ctl.busy, out_valid_q && !ctl.busy, "pop read did not finish")
	`DEQ_ASSERT_SAME(a_ovf_full, clk, arst_n, out_valid && (status == ST_OVERFLOW), is_full, "overflow while not full")
	`DEQ_ASSERT_SAME(a_unf_empty, clk, arst_n, out_valid && (status == ST_UNDERFLOW), is_empty && (popped_value == '0), "underflow while not empty")

endmodule
